>>> hw/rtl/lsrc_pkg.sv
package lsrc_pkg;

   localparam int CW    = 16;             // coordinate width
   localparam int FW    = 16;             // fraction bits of a crossing
   localparam int DW    = CW + 1;         // coordinate difference
   localparam int PW    = 2 * DW;         // product of two differences
   localparam int QW    = DW + FW;        // quotient bits, one divider step each
   localparam int RW    = DW + 1;         // trial remainder
   localparam int CFW   = CW + FW + 3;    // signed crossing
   localparam int NLANE = 4;

   localparam int EDGE_TOP    = 0;
   localparam int EDGE_BOTTOM = 1;
   localparam int EDGE_LEFT   = 2;
   localparam int EDGE_RIGHT  = 3;

   localparam int IDX_LEFT   = 0;
   localparam int IDX_RIGHT  = 1;
   localparam int IDX_TOP    = 2;
   localparam int IDX_BOTTOM = 3;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic          ok;
      logic          neg;
      logic [DW-1:0] u;
      logic [DW-1:0] v;
      logic [DW-1:0] d;
      logic [PW-1:0] prod;
      logic [QW-1:0] q;
   } lane_type;

   typedef struct packed {
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
      coord_type xl;
      coord_type xh;
      coord_type yl;
      coord_type yh;
      lane_type [NLANE-1:0] lane;
   } item_type;

   function automatic logic strictly_in(input logic signed [CFW-1:0] c,
                                        input coord_type a, input coord_type b);
      logic signed [CFW-1:0] aw;
      logic signed [CFW-1:0] bw;
      logic signed [CFW-1:0] lo;
      logic signed [CFW-1:0] hi;
      aw = CFW'(a) <<< FW;
      bw = CFW'(b) <<< FW;
      lo = (aw < bw) ? aw : bw;
      hi = (aw < bw) ? bw : aw;
      return (lo < c) && (c < hi);
   endfunction

   function automatic coord_type trunc_fix(input logic signed [CFW-1:0] c);
      logic signed [CFW-1:0] m;
      m = c[CFW-1] ? -c : c;
      m = m >>> FW;
      if (c[CFW-1]) begin
         m = -m;
      end
      return m[CW-1:0];
   endfunction

endpackage

>>> hw/rtl/line_segment_rectangle_clip.sv
// Segment clipper against a programmable rectangle.
// Request channel: req_valid with the two endpoints; a request is taken when
// req_valid is high and req_stall is low. Response channel: rsp_valid with the
// clipped endpoints and a reject flag, taken when rsp_valid is high and
// rsp_stall is low. Rejected segments read back as all -1.
// The four bounds are written through csr_write_enable/csr_index/csr_data;
// the user must write them only while the block is empty, as the block does
// not enforce it. Each pair is ordered internally. Throughput: one request
// per cycle while the response is not stalled. Three setup stages (input
// register, differences, product), one stage per quotient bit of the four
// parallel long dividers (33), and three stages for crossing, tests, select.
// The whole pipeline advances together; when the response is stalled every
// stage holds and req_stall rises in the same cycle, so nothing is dropped.
// Reset empties the pipeline and restores the default bounds
// (0, 32767, 0, 32767).
module line_segment_rectangle_clip (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lsrc_pkg::coord_type req_start_x,
   input  lsrc_pkg::coord_type req_start_y,
   input  lsrc_pkg::coord_type req_end_x,
   input  lsrc_pkg::coord_type req_end_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lsrc_pkg::coord_type rsp_clipped_start_x,
   output lsrc_pkg::coord_type rsp_clipped_start_y,
   output lsrc_pkg::coord_type rsp_clipped_end_x,
   output lsrc_pkg::coord_type rsp_clipped_end_y,
   output logic                rsp_rejected,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  lsrc_pkg::coord_type csr_data
);

   lsrc_pkg::coord_type left_ff, right_ff, top_ff, bottom_ff;
   lsrc_pkg::coord_type xl, xh, yl, yh;
   logic adv;
   logic fr_valid, dv_valid;
   lsrc_pkg::item_type fr_item, dv_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= lsrc_pkg::coord_type'(0);
         right_ff  <= lsrc_pkg::coord_type'(32767);
         top_ff    <= lsrc_pkg::coord_type'(0);
         bottom_ff <= lsrc_pkg::coord_type'(32767);
      end else if (csr_write_enable) begin
         case (csr_index)
            2'(lsrc_pkg::IDX_LEFT):   left_ff   <= csr_data;
            2'(lsrc_pkg::IDX_RIGHT):  right_ff  <= csr_data;
            2'(lsrc_pkg::IDX_TOP):    top_ff    <= csr_data;
            2'(lsrc_pkg::IDX_BOTTOM): bottom_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign xl = (left_ff < right_ff) ? left_ff : right_ff;
   assign xh = (left_ff < right_ff) ? right_ff : left_ff;
   assign yl = (top_ff < bottom_ff) ? top_ff : bottom_ff;
   assign yh = (top_ff < bottom_ff) ? bottom_ff : top_ff;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   lsrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .x1        (req_start_x),
      .y1        (req_start_y),
      .x2        (req_end_x),
      .y2        (req_end_y),
      .xl        (xl),
      .xh        (xh),
      .yl        (yl),
      .yh        (yh),
      .out_valid (fr_valid),
      .out_item  (fr_item)
   );

   lsrc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_item   (fr_item),
      .out_valid (dv_valid),
      .out_item  (dv_item)
   );

   lsrc_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (dv_valid),
      .in_item      (dv_item),
      .out_valid    (rsp_valid),
      .out_start_x  (rsp_clipped_start_x),
      .out_start_y  (rsp_clipped_start_y),
      .out_end_x    (rsp_clipped_end_x),
      .out_end_y    (rsp_clipped_end_y),
      .out_rejected (rsp_rejected)
   );

endmodule

>>> hw/rtl/lsrc_front.sv
module lsrc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lsrc_pkg::coord_type x1,
   input  lsrc_pkg::coord_type y1,
   input  lsrc_pkg::coord_type x2,
   input  lsrc_pkg::coord_type y2,
   input  lsrc_pkg::coord_type xl,
   input  lsrc_pkg::coord_type xh,
   input  lsrc_pkg::coord_type yl,
   input  lsrc_pkg::coord_type yh,
   output logic                out_valid,
   output lsrc_pkg::item_type  out_item
);

   function automatic lsrc_pkg::lane_type lane_prep(input lsrc_pkg::coord_type a1,
      input lsrc_pkg::coord_type a2, input lsrc_pkg::coord_type b1,
      input lsrc_pkg::coord_type b2, input lsrc_pkg::coord_type s);
      logic signed [lsrc_pkg::DW-1:0] du;
      logic signed [lsrc_pkg::DW-1:0] dv;
      logic signed [lsrc_pkg::DW-1:0] dd;
      lsrc_pkg::lane_type l;
      du = lsrc_pkg::DW'(s) - lsrc_pkg::DW'(a1);
      dv = lsrc_pkg::DW'(b2) - lsrc_pkg::DW'(b1);
      dd = lsrc_pkg::DW'(a2) - lsrc_pkg::DW'(a1);
      l = '0;
      l.ok = (a1 < s && s < a2) || (a2 < s && s < a1);
      l.neg = (du[lsrc_pkg::DW-1] ^ dv[lsrc_pkg::DW-1] ^ dd[lsrc_pkg::DW-1]) && (dv != '0);
      l.u = du[lsrc_pkg::DW-1] ? -du : du;
      l.v = dv[lsrc_pkg::DW-1] ? -dv : dv;
      l.d = dd[lsrc_pkg::DW-1] ? -dd : dd;
      return l;
   endfunction

   lsrc_pkg::item_type s0_ff, s1_ff, s2_ff;
   lsrc_pkg::item_type s0_in, s1_in, s2_in;
   logic v0_ff, v1_ff, v2_ff;

   always_comb begin
      s0_in = '0;
      s0_in.x1 = x1;
      s0_in.y1 = y1;
      s0_in.x2 = x2;
      s0_in.y2 = y2;
      s0_in.xl = xl;
      s0_in.xh = xh;
      s0_in.yl = yl;
      s0_in.yh = yh;
   end

   always_comb begin
      s1_in = s0_ff;
      s1_in.lane[lsrc_pkg::EDGE_TOP] =
         lane_prep(s0_ff.y1, s0_ff.y2, s0_ff.x1, s0_ff.x2, s0_ff.yl);
      s1_in.lane[lsrc_pkg::EDGE_BOTTOM] =
         lane_prep(s0_ff.y1, s0_ff.y2, s0_ff.x1, s0_ff.x2, s0_ff.yh);
      s1_in.lane[lsrc_pkg::EDGE_LEFT] =
         lane_prep(s0_ff.x1, s0_ff.x2, s0_ff.y1, s0_ff.y2, s0_ff.xl);
      s1_in.lane[lsrc_pkg::EDGE_RIGHT] =
         lane_prep(s0_ff.x1, s0_ff.x2, s0_ff.y1, s0_ff.y2, s0_ff.xh);
   end

   always_comb begin
      s2_in = s1_ff;
      for (int e = 0; e < lsrc_pkg::NLANE; e++) begin
         s2_in.lane[e].prod = lsrc_pkg::PW'(s1_ff.lane[e].u) * lsrc_pkg::PW'(s1_ff.lane[e].v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = s2_ff;

endmodule

>>> hw/rtl/lsrc_divider.sv
module lsrc_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  lsrc_pkg::item_type in_item,
   output logic               out_valid,
   output lsrc_pkg::item_type out_item
);

   lsrc_pkg::item_type pipe_ff [lsrc_pkg::QW];
   logic [lsrc_pkg::NLANE-1:0][lsrc_pkg::DW-1:0] rem_ff [lsrc_pkg::QW];
   logic [lsrc_pkg::QW-1:0] vld_ff;

   for (genvar i = 0; i < lsrc_pkg::QW; i++) begin : g_step
      localparam int J = lsrc_pkg::QW - 1 - i;
      lsrc_pkg::item_type prev;
      lsrc_pkg::item_type pipe_in;
      logic [lsrc_pkg::NLANE-1:0][lsrc_pkg::DW-1:0] rprev;
      logic [lsrc_pkg::NLANE-1:0][lsrc_pkg::DW-1:0] rem_in;
      logic [lsrc_pkg::NLANE-1:0] nb;
      logic vprev;

      if (i == 0) begin : g_first
         assign prev  = in_item;
         assign vprev = in_valid;
         for (genvar e = 0; e < lsrc_pkg::NLANE; e++) begin : g_r
            assign rprev[e] = in_item.lane[e].prod[lsrc_pkg::PW-1:lsrc_pkg::DW];
         end
      end else begin : g_next
         assign prev  = pipe_ff[i-1];
         assign vprev = vld_ff[i-1];
         assign rprev = rem_ff[i-1];
      end

      if (J >= lsrc_pkg::FW) begin : g_bit
         for (genvar e = 0; e < lsrc_pkg::NLANE; e++) begin : g_b
            assign nb[e] = prev.lane[e].prod[J-lsrc_pkg::FW];
         end
      end else begin : g_zero
         assign nb = '0;
      end

      always_comb begin
         logic [lsrc_pkg::RW-1:0] t;
         logic [lsrc_pkg::RW-1:0] dx;
         logic ge;
         pipe_in = prev;
         for (int e = 0; e < lsrc_pkg::NLANE; e++) begin
            t  = {rprev[e], nb[e]};
            dx = lsrc_pkg::RW'(prev.lane[e].d);
            ge = (t >= dx);
            rem_in[e] = ge ? lsrc_pkg::DW'(t - dx) : lsrc_pkg::DW'(t);
            pipe_in.lane[e].q = {prev.lane[e].q[lsrc_pkg::QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vprev;
         end
         if (adv) begin
            pipe_ff[i] <= pipe_in;
            rem_ff[i]  <= rem_in;
         end
      end
   end

   assign out_valid = vld_ff[lsrc_pkg::QW-1];
   assign out_item  = pipe_ff[lsrc_pkg::QW-1];

endmodule

>>> hw/rtl/lsrc_finish.sv
module lsrc_finish (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  lsrc_pkg::item_type  in_item,
   output logic                out_valid,
   output lsrc_pkg::coord_type out_start_x,
   output lsrc_pkg::coord_type out_start_y,
   output lsrc_pkg::coord_type out_end_x,
   output lsrc_pkg::coord_type out_end_y,
   output logic                out_rejected
);

   lsrc_pkg::item_type f1_ff, f2_ff;
   logic signed [lsrc_pkg::CFW-1:0] c_ff [lsrc_pkg::NLANE];
   logic signed [lsrc_pkg::CFW-1:0] c_in [lsrc_pkg::NLANE];
   logic [lsrc_pkg::NLANE-1:0] hit_ff, hit_in;
   lsrc_pkg::coord_type tr_ff [lsrc_pkg::NLANE];
   lsrc_pkg::coord_type tr_in [lsrc_pkg::NLANE];
   logic v1_ff, v2_ff, v3_ff;
   lsrc_pkg::coord_type sx_ff, sy_ff, ex_ff, ey_ff;
   lsrc_pkg::coord_type sx_in, sy_in, ex_in, ey_in;
   logic rej_ff, rej_in;

   always_comb begin
      lsrc_pkg::coord_type b1;
      logic signed [lsrc_pkg::CFW-1:0] qs;
      for (int e = 0; e < lsrc_pkg::NLANE; e++) begin
         b1 = (e == lsrc_pkg::EDGE_TOP || e == lsrc_pkg::EDGE_BOTTOM) ? in_item.x1 : in_item.y1;
         qs = $signed(lsrc_pkg::CFW'(in_item.lane[e].q));
         c_in[e] = (lsrc_pkg::CFW'(b1) <<< lsrc_pkg::FW) + (in_item.lane[e].neg ? -qs : qs);
      end
   end

   always_comb begin
      for (int e = 0; e < lsrc_pkg::NLANE; e++) begin
         if (e == lsrc_pkg::EDGE_TOP || e == lsrc_pkg::EDGE_BOTTOM) begin
            hit_in[e] = f1_ff.lane[e].ok &&
                        lsrc_pkg::strictly_in(c_ff[e], f1_ff.x1, f1_ff.x2) &&
                        lsrc_pkg::strictly_in(c_ff[e], f1_ff.xl, f1_ff.xh);
         end else begin
            hit_in[e] = f1_ff.lane[e].ok &&
                        lsrc_pkg::strictly_in(c_ff[e], f1_ff.y1, f1_ff.y2) &&
                        lsrc_pkg::strictly_in(c_ff[e], f1_ff.yl, f1_ff.yh);
         end
         tr_in[e] = lsrc_pkg::trunc_fix(c_ff[e]);
      end
   end

   // later edges override earlier ones
   always_comb begin
      sx_in = f2_ff.x1;
      sy_in = f2_ff.y1;
      ex_in = f2_ff.x2;
      ey_in = f2_ff.y2;
      if (hit_ff[lsrc_pkg::EDGE_TOP]) begin
         if (f2_ff.y2 < f2_ff.y1) begin
            ey_in = f2_ff.yl; ex_in = tr_ff[lsrc_pkg::EDGE_TOP];
         end else begin
            sy_in = f2_ff.yl; sx_in = tr_ff[lsrc_pkg::EDGE_TOP];
         end
      end
      if (hit_ff[lsrc_pkg::EDGE_BOTTOM]) begin
         if (f2_ff.y2 > f2_ff.y1) begin
            ey_in = f2_ff.yh; ex_in = tr_ff[lsrc_pkg::EDGE_BOTTOM];
         end else begin
            sy_in = f2_ff.yh; sx_in = tr_ff[lsrc_pkg::EDGE_BOTTOM];
         end
      end
      if (hit_ff[lsrc_pkg::EDGE_LEFT]) begin
         if (f2_ff.x2 < f2_ff.x1) begin
            ex_in = f2_ff.xl; ey_in = tr_ff[lsrc_pkg::EDGE_LEFT];
         end else begin
            sx_in = f2_ff.xl; sy_in = tr_ff[lsrc_pkg::EDGE_LEFT];
         end
      end
      if (hit_ff[lsrc_pkg::EDGE_RIGHT]) begin
         if (f2_ff.x2 > f2_ff.x1) begin
            ex_in = f2_ff.xh; ey_in = tr_ff[lsrc_pkg::EDGE_RIGHT];
         end else begin
            sx_in = f2_ff.xh; sy_in = tr_ff[lsrc_pkg::EDGE_RIGHT];
         end
      end
      rej_in = (hit_ff == '0) && (f2_ff.x1 > f2_ff.xh || f2_ff.x1 < f2_ff.xl);
      if (rej_in) begin
         sx_in = '1; sy_in = '1; ex_in = '1; ey_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         f1_ff  <= in_item;
         c_ff   <= c_in;
         f2_ff  <= f1_ff;
         hit_ff <= hit_in;
         tr_ff  <= tr_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         ex_ff  <= ex_in;
         ey_ff  <= ey_in;
         rej_ff <= rej_in;
      end
   end

   assign out_valid    = v3_ff;
   assign out_start_x  = sx_ff;
   assign out_start_y  = sy_ff;
   assign out_end_x    = ex_ff;
   assign out_end_y    = ey_ff;
   assign out_rejected = rej_ff;

endmodule

>>> hw/rtl/lsrc_checker.sv
module lsrc_port_checks (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input lsrc_pkg::coord_type req_start_x,
   input lsrc_pkg::coord_type req_start_y,
   input lsrc_pkg::coord_type req_end_x,
   input lsrc_pkg::coord_type req_end_y,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input lsrc_pkg::coord_type rsp_clipped_start_x,
   input lsrc_pkg::coord_type rsp_clipped_start_y,
   input lsrc_pkg::coord_type rsp_clipped_end_x,
   input lsrc_pkg::coord_type rsp_clipped_end_y,
   input logic                rsp_rejected,
   input logic                csr_write_enable,
   input logic [1:0]          csr_index,
   input lsrc_pkg::coord_type csr_data
);

   a_reject_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_clipped_start_x == '1 &&
      rsp_clipped_start_y == '1 && rsp_clipped_end_x == '1 && rsp_clipped_end_y == '1)
      else $error("rejected response with coordinates other than -1");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_clipped_start_x) &&
      $stable(rsp_clipped_end_y) && $stable(rsp_rejected))
      else $error("stalled response changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind line_segment_rectangle_clip lsrc_port_checks u_checker (.*);

>>> bench/lsrc_checker.sv
`timescale 1ns / 1ps
module lsrc_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  lsrc_pkg::coord_type req_start_x,
   input  lsrc_pkg::coord_type req_start_y,
   input  lsrc_pkg::coord_type req_end_x,
   input  lsrc_pkg::coord_type req_end_y,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  lsrc_pkg::coord_type rsp_clipped_start_x,
   input  lsrc_pkg::coord_type rsp_clipped_start_y,
   input  lsrc_pkg::coord_type rsp_clipped_end_x,
   input  lsrc_pkg::coord_type rsp_clipped_end_y,
   input  logic                rsp_rejected,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  lsrc_pkg::coord_type csr_data,
   output int                  errors,
   output int                  pending
);

   typedef struct packed {
      lsrc_pkg::coord_type sx;
      lsrc_pkg::coord_type sy;
      lsrc_pkg::coord_type ex;
      lsrc_pkg::coord_type ey;
      logic                rej;
   } clip_type;

   longint bound [4];
   clip_type clip_q [$];

   // crossing of the segment line with a = s, Q16; 0 return when outside span
   function automatic bit cross_at(longint a1, longint a2, longint b1, longint b2,
                                   longint s, output longint c);
      longint lo, hi, num, dd;
      lo = a1 < a2 ? a1 : a2;
      hi = a1 < a2 ? a2 : a1;
      if (!(lo < s && s < hi)) return 0;
      num = (s - a1) * (b2 - b1) * 65536;
      dd = a2 - a1;
      c = b1 * 65536 + num / dd;
      return 1;
   endfunction

   function automatic bit inside_open(longint c, longint a, longint b);
      longint lo, hi;
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      return lo * 65536 < c && c < hi * 65536;
   endfunction

   function automatic longint to_int(longint c);
      return c >= 0 ? c >>> 16 : -((-c) >>> 16);
   endfunction

   function automatic clip_type clip_segment(longint x1, longint y1,
                                              longint x2, longint y2);
      longint xl, xh, yl, yh, nx1, ny1, nx2, ny2, c;
      int hits;
      clip_type r;
      xl = bound[lsrc_pkg::IDX_LEFT] < bound[lsrc_pkg::IDX_RIGHT] ?
           bound[lsrc_pkg::IDX_LEFT] : bound[lsrc_pkg::IDX_RIGHT];
      xh = bound[lsrc_pkg::IDX_LEFT] < bound[lsrc_pkg::IDX_RIGHT] ?
           bound[lsrc_pkg::IDX_RIGHT] : bound[lsrc_pkg::IDX_LEFT];
      yl = bound[lsrc_pkg::IDX_TOP] < bound[lsrc_pkg::IDX_BOTTOM] ?
           bound[lsrc_pkg::IDX_TOP] : bound[lsrc_pkg::IDX_BOTTOM];
      yh = bound[lsrc_pkg::IDX_TOP] < bound[lsrc_pkg::IDX_BOTTOM] ?
           bound[lsrc_pkg::IDX_BOTTOM] : bound[lsrc_pkg::IDX_TOP];
      nx1 = x1; ny1 = y1; nx2 = x2; ny2 = y2; hits = 0;
      if (cross_at(y1, y2, x1, x2, yl, c) && inside_open(c, x1, x2)
          && inside_open(c, xl, xh)) begin
         if (y2 < y1) begin ny2 = yl; nx2 = to_int(c); end
         else begin ny1 = yl; nx1 = to_int(c); end
         hits++;
      end
      if (cross_at(y1, y2, x1, x2, yh, c) && inside_open(c, x1, x2)
          && inside_open(c, xl, xh)) begin
         if (y2 > y1) begin ny2 = yh; nx2 = to_int(c); end
         else begin ny1 = yh; nx1 = to_int(c); end
         hits++;
      end
      if (cross_at(x1, x2, y1, y2, xl, c) && inside_open(c, y1, y2)
          && inside_open(c, yl, yh)) begin
         if (x2 < x1) begin nx2 = xl; ny2 = to_int(c); end
         else begin nx1 = xl; ny1 = to_int(c); end
         hits++;
      end
      if (cross_at(x1, x2, y1, y2, xh, c) && inside_open(c, y1, y2)
          && inside_open(c, yl, yh)) begin
         if (x2 > x1) begin nx2 = xh; ny2 = to_int(c); end
         else begin nx1 = xh; ny1 = to_int(c); end
         hits++;
      end
      if (hits == 0 && (x1 > xh || x1 < xl)) begin
         r = '{'1, '1, '1, '1, 1'b1};
      end else begin
         r = '{lsrc_pkg::coord_type'(nx1), lsrc_pkg::coord_type'(ny1),
               lsrc_pkg::coord_type'(nx2), lsrc_pkg::coord_type'(ny2), 1'b0};
      end
      return r;
   endfunction

   always @(posedge clock) begin
      clip_type want, got;
      if (reset) begin
         bound[lsrc_pkg::IDX_LEFT] = 0; bound[lsrc_pkg::IDX_RIGHT] = 32767;
         bound[lsrc_pkg::IDX_TOP] = 0; bound[lsrc_pkg::IDX_BOTTOM] = 32767;
         clip_q.delete();
         errors = 0;
         pending = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_clipped_start_x, rsp_clipped_start_y, rsp_clipped_end_x,
                    rsp_clipped_end_y, rsp_rejected};
            if (clip_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response %p", got);
            end else begin
               want = clip_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
               end
            end
         end
         if (req_valid && !req_stall)
            clip_q.push_back(clip_segment(req_start_x, req_start_y,
                                          req_end_x, req_end_y));
         if (csr_write_enable) bound[csr_index] = longint'(csr_data);
         pending = clip_q.size();
      end
   end
endmodule

>>> bench/tb_line_segment_rectangle_clip.sv
`timescale 1ns / 1ps
module tb_line_segment_rectangle_clip;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_write_enable = 0;
   logic req_stall, rsp_valid, rsp_rejected;
   lsrc_pkg::coord_type req_start_x = 0, req_start_y = 0, req_end_x = 0, req_end_y = 0;
   lsrc_pkg::coord_type rsp_clipped_start_x, rsp_clipped_start_y;
   lsrc_pkg::coord_type rsp_clipped_end_x, rsp_clipped_end_y;
   logic [1:0] csr_index = 0;
   lsrc_pkg::coord_type csr_data = 0;
   int errors, pending, cycles = 0;
   int send_idle = 0, recv_idle = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   line_segment_rectangle_clip dut (.*);
   lsrc_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb_line_segment_rectangle_clip NOT OK");
         $finish;
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   task automatic send(lsrc_pkg::coord_type sx, lsrc_pkg::coord_type sy,
                       lsrc_pkg::coord_type ex, lsrc_pkg::coord_type ey);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_start_x <= sx; req_start_y <= sy; req_end_x <= ex; req_end_y <= ey;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic set_bound(logic [1:0] idx, lsrc_pkg::coord_type v);
      csr_write_enable <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic set_rect(lsrc_pkg::coord_type l, lsrc_pkg::coord_type r,
                           lsrc_pkg::coord_type t, lsrc_pkg::coord_type b);
      set_bound(2'(lsrc_pkg::IDX_LEFT), l); set_bound(2'(lsrc_pkg::IDX_RIGHT), r);
      set_bound(2'(lsrc_pkg::IDX_TOP), t); set_bound(2'(lsrc_pkg::IDX_BOTTOM), b);
   endtask

   function automatic lsrc_pkg::coord_type near(lsrc_pkg::coord_type a,
                                                lsrc_pkg::coord_type b);
      int lo, hi;
      lo = (a < b ? a : b) - 200; hi = (a < b ? b : a) + 200;
      if (lo < -32768) lo = -32768;
      if (hi > 32767) hi = 32767;
      return lsrc_pkg::coord_type'($urandom_range(hi - lo) + lo);
   endfunction

   task automatic random_phase(int n, lsrc_pkg::coord_type l, lsrc_pkg::coord_type r,
                               lsrc_pkg::coord_type t, lsrc_pkg::coord_type b);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0)
            send(lsrc_pkg::coord_type'($urandom), lsrc_pkg::coord_type'($urandom),
                 lsrc_pkg::coord_type'($urandom), lsrc_pkg::coord_type'($urandom));
         else if ($urandom_range(9) == 0)
            send(near(l, r), t, near(l, r), t);
         else
            send(near(l, r), near(t, b), near(l, r), near(t, b));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle = 19; recv_idle = 80;
      // default rectangle
      send(-100, 50, 100, 50);
      send(50, -100, 50, 40000 - 65536);
      send(100, 100, 200, 200);
      send(-5, -5, -5, 10);
      send(10, 0, 20, 0);
      send(-32768, -32768, 32767, 32767);
      send(32767, 32767, -32768, -32768);
      send(-32768, 32767, 32767, -32768);
      send(40, 0, 40, 50);
      send(-1, -1, 0, 0);
      drain();
      set_rect(50, -50, 40, -40);
      send(-100, 0, 100, 0);
      send(0, -100, 0, 100);
      send(100, 0, -100, 0);
      send(0, 100, 0, -100);
      send(-100, -100, 100, 100);
      send(-99, 7, 93, -33);
      send(60, 60, 70, 70);
      send(-50, 0, -50, 10);
      send(0, 0, 10, 10);
      drain();
      set_rect(-32768, 32767, 32767, -32768);
      send(-32768, 0, 32767, 1);
      send(0, -32768, 3, 32767);
      random_phase(300, -32768, 32767, -32768, 32767);
      drain();
      set_rect(-300, 200, -150, 400);
      random_phase(350, -300, 200, -150, 400);
      drain();
      send_idle = 80; recv_idle = 19;
      set_rect(7, 7, 3, 3);
      random_phase(150, 7, 7, 3, 3);
      drain();
      set_rect(1000, -1000, 500, -500);
      random_phase(200, -1000, 1000, -500, 500);
      drain();
      send_idle = 0; recv_idle = 0;
      set_rect(-20, 30, -10, 25);
      random_phase(300, -20, 30, -10, 25);
      drain();
      if (errors == 0) $display("tb_line_segment_rectangle_clip OK");
      else $display("tb_line_segment_rectangle_clip NOT OK");
      $finish;
   end
endmodule
